// ===== hdl/clipped_color_key_sprite_blit_core_assert.svh =====
// Assertion macros shared by the sprite blitter modules.
`ifndef CLIPPED_COLOR_KEY_SPRITE_BLIT_CORE_ASSERT_SVH
`define CLIPPED_COLOR_KEY_SPRITE_BLIT_CORE_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define CCKB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite blitter check failed");

// Checks that cons holds in the cycle after ante.
`define CCKB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite blitter check failed");

`endif

// ===== hdl/cckb_pkg.sv =====
// Package with the shared types and constants of the sprite blitter.
package cckb_pkg;

	localparam int DIM_FIELD_W = 11;
	localparam int COORD_W = 16;
	localparam int PIX_FIELD_W = 16;
	localparam int ADDR_W = 20;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CORNER_W = 17;
	localparam int POS_W = 18;

	localparam int MAX_DIM_DEF = 1024;
	localparam int PIXEL_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] DEST_WIDTH_RST = 11'd640;
	localparam logic [CFG_W-1:0] DEST_HEIGHT_RST = 11'd480;
	localparam logic [CFG_W-1:0] CLIP_RIGHT_RST = 11'd640;
	localparam logic [CFG_W-1:0] CLIP_BOTTOM_RST = 11'd480;

	typedef enum logic [0:0] {
		CMD_BEGIN = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH  = 3'd0,
		REG_DEST_HEIGHT = 3'd1,
		REG_CLIP_MODE   = 3'd2,
		REG_CLIP_LEFT   = 3'd3,
		REG_CLIP_TOP    = 3'd4,
		REG_CLIP_RIGHT  = 3'd5,
		REG_CLIP_BOTTOM = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] left;
		logic [CFG_W-1:0] top;
		logic [CFG_W-1:0] right;
		logic [CFG_W-1:0] bottom;
		logic [CFG_W-1:0] dest_width;
	} win_t;

	typedef struct packed {
		logic                   valid;
		logic                   write_enable;
		logic [CFG_W-1:0]       x;
		logic [CFG_W-1:0]       y;
		logic [PIX_FIELD_W-1:0] pixel;
		logic                   rejected;
		logic                   last;
	} stage_t;

endpackage

// ===== hdl/cckb_req_if.sv =====
// Request channel carrying begin and pixel items into the blitter.
interface cckb_req_if;
	import cckb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [DIM_FIELD_W-1:0]    sprite_width;
	logic [DIM_FIELD_W-1:0]    sprite_height;
	logic signed [COORD_W-1:0] origin_x;
	logic signed [COORD_W-1:0] origin_y;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic [PIX_FIELD_W-1:0]    pixel;

	modport source (
		output valid, cmd, sprite_width, sprite_height, origin_x, origin_y,
			pos_x, pos_y, pixel,
		input ready
	);
	modport sink (
		input valid, cmd, sprite_width, sprite_height, origin_x, origin_y,
			pos_x, pos_y, pixel,
		output ready
	);
endinterface

// ===== hdl/cckb_rsp_if.sv =====
// Result channel carrying destination writes out of the blitter.
interface cckb_rsp_if;
	import cckb_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   write_enable;
	logic [ADDR_W-1:0]      dest_addr;
	logic [PIX_FIELD_W-1:0] write_pixel;
	logic                   rejected;
	logic                   last;

	modport source (
		output valid, write_enable, dest_addr, write_pixel, rejected, last,
		input ready
	);
	modport sink (
		input valid, write_enable, dest_addr, write_pixel, rejected, last,
		output ready
	);
endinterface

// ===== hdl/cckb_cfg_regs.sv =====
// Configuration registers and clip window selection.
module cckb_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cckb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cckb_pkg::CFG_W-1:0]     cfg_wdata,
	output cckb_pkg::win_t                win
);
	import cckb_pkg::*;

	logic [CFG_W-1:0] dest_width_q;
	logic [CFG_W-1:0] dest_height_q;
	logic             clip_mode_q;
	logic [CFG_W-1:0] clip_left_q;
	logic [CFG_W-1:0] clip_top_q;
	logic [CFG_W-1:0] clip_right_q;
	logic [CFG_W-1:0] clip_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q  <= DEST_WIDTH_RST;
			dest_height_q <= DEST_HEIGHT_RST;
			clip_mode_q   <= 1'b0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= CLIP_RIGHT_RST;
			clip_bottom_q <= CLIP_BOTTOM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEST_WIDTH:  dest_width_q  <= cfg_wdata;
				REG_DEST_HEIGHT: dest_height_q <= cfg_wdata;
				REG_CLIP_MODE:   clip_mode_q   <= cfg_wdata[0];
				REG_CLIP_LEFT:   clip_left_q   <= cfg_wdata;
				REG_CLIP_TOP:    clip_top_q    <= cfg_wdata;
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata;
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		win.dest_width = dest_width_q;
		if (clip_mode_q) begin
			win.left   = clip_left_q;
			win.top    = clip_top_q;
			win.right  = clip_right_q;
			win.bottom = clip_bottom_q;
		end else begin
			win.left   = '0;
			win.top    = '0;
			win.right  = dest_width_q;
			win.bottom = dest_height_q;
		end
	end
endmodule

// ===== hdl/cckb_geom.sv =====
// Input register, sprite state, raster counters and clip test.
module cckb_geom #(
	parameter int MAX_DIM = cckb_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = cckb_pkg::PIXEL_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	cckb_req_if.sink        req,
	input  cckb_pkg::win_t  win,
	input  logic            ready_s2,
	output cckb_pkg::stage_t stage_s2
);
	import cckb_pkg::*;

	`include "clipped_color_key_sprite_blit_core_assert.svh"

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;

	logic                      valid_s1;
	logic                      cmd_s1;
	logic [DIM_FIELD_W-1:0]    sprite_width_s1;
	logic [DIM_FIELD_W-1:0]    sprite_height_s1;
	logic signed [COORD_W-1:0] origin_x_s1;
	logic signed [COORD_W-1:0] origin_y_s1;
	logic signed [COORD_W-1:0] pos_x_s1;
	logic signed [COORD_W-1:0] pos_y_s1;
	logic [PW-1:0]             pixel_s1;

	logic signed [CORNER_W-1:0] corner_x_q;
	logic signed [CORNER_W-1:0] corner_y_q;
	logic [DW-1:0]              width_q;
	logic [DW-1:0]              height_q;
	logic [DW-1:0]              col_q;
	logic [DW-1:0]              row_q;
	logic                       reject_q;

	logic                       adv_s1;
	logic                       take;
	logic signed [CORNER_W-1:0] new_cx;
	logic signed [CORNER_W-1:0] new_cy;
	logic [DW-1:0]              new_w;
	logic [DW-1:0]              new_h;
	logic                       new_reject;
	logic signed [POS_W-1:0]    wl;
	logic signed [POS_W-1:0]    wt;
	logic signed [POS_W-1:0]    wr;
	logic signed [POS_W-1:0]    wb;
	logic signed [POS_W-1:0]    x_pos;
	logic signed [POS_W-1:0]    y_pos;
	logic                       active;
	logic                       in_window;
	logic                       col_end;
	logic                       row_end;
	stage_t                     nxt;

	function automatic logic [DW-1:0] clamp_dim(input logic [DIM_FIELD_W-1:0] v);
		logic [DW-1:0] d;
		if (32'(v) > MAX_DIM) begin
			d = DW'(MAX_DIM);
		end else begin
			d = DW'(v);
		end
		return d;
	endfunction

	assign adv_s1 = !stage_s2.valid || ready_s2;
	assign req.ready = !valid_s1 || adv_s1;
	assign take = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1           <= req.cmd;
			sprite_width_s1  <= req.sprite_width;
			sprite_height_s1 <= req.sprite_height;
			origin_x_s1      <= req.origin_x;
			origin_y_s1      <= req.origin_y;
			pos_x_s1         <= req.pos_x;
			pos_y_s1         <= req.pos_y;
			pixel_s1         <= req.pixel[PW-1:0];
		end
	end

	always_comb begin
		wl = POS_W'(win.left);
		wt = POS_W'(win.top);
		wr = POS_W'(win.right);
		wb = POS_W'(win.bottom);

		new_cx = CORNER_W'(pos_x_s1) - CORNER_W'(origin_x_s1);
		new_cy = CORNER_W'(pos_y_s1) - CORNER_W'(origin_y_s1);
		new_w = clamp_dim(sprite_width_s1);
		new_h = clamp_dim(sprite_height_s1);
		new_reject = (POS_W'(new_cx) >= wr)
			|| (POS_W'(new_cx) + $signed(POS_W'(new_w)) <= wl)
			|| (POS_W'(new_cy) >= wb)
			|| (POS_W'(new_cy) + $signed(POS_W'(new_h)) <= wt);

		x_pos = POS_W'(corner_x_q) + $signed(POS_W'(col_q));
		y_pos = POS_W'(corner_y_q) + $signed(POS_W'(row_q));
		active = (width_q != '0) && (row_q < height_q);
		in_window = !reject_q && (x_pos >= wl) && (x_pos < wr)
			&& (y_pos >= wt) && (y_pos < wb);
		col_end = ({1'b0, col_q} + 1'b1) == {1'b0, width_q};
		row_end = ({1'b0, row_q} + 1'b1) == {1'b0, height_q};

		nxt = '0;
		nxt.valid = valid_s1;
		if (cmd_s1 == CMD_BEGIN) begin
			nxt.rejected = new_reject;
		end else begin
			nxt.rejected = reject_q;
			if (active) begin
				nxt.write_enable = in_window && (pixel_s1 != '0);
				nxt.x = x_pos[CFG_W-1:0];
				nxt.y = y_pos[CFG_W-1:0];
				nxt.pixel = PIX_FIELD_W'(pixel_s1);
				nxt.last = col_end && row_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_x_q <= '0;
			corner_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			reject_q   <= 1'b0;
		end else if (take) begin
			if (cmd_s1 == CMD_BEGIN) begin
				corner_x_q <= new_cx;
				corner_y_q <= new_cy;
				width_q    <= new_w;
				height_q   <= new_h;
				col_q      <= '0;
				row_q      <= '0;
				reject_q   <= new_reject;
			end else if (active) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else if (take) begin
			stage_s2 <= nxt;
		end else if (adv_s1) begin
			stage_s2.valid <= 1'b0;
		end
	end

	`CCKB_ASSERT_SAME(a_row_in_range, clk, arst_n, 1'b1, row_q <= height_q)
	`CCKB_ASSERT_SAME(a_col_in_range, clk, arst_n, col_q != '0, col_q < width_q)
	`CCKB_ASSERT_NEXT(a_req_loads_s1, clk, arst_n, req.valid && req.ready, valid_s1)
endmodule

// ===== hdl/cckb_addr.sv =====
// Address multiply and result register.
module cckb_addr (
	input  logic             clk,
	input  logic             arst_n,
	input  cckb_pkg::stage_t stage_s2,
	input  cckb_pkg::win_t   win,
	output logic             ready_s2,
	cckb_rsp_if.source       rsp
);
	import cckb_pkg::*;

	`include "clipped_color_key_sprite_blit_core_assert.svh"

	logic [2*CFG_W-1:0] row_base;
	logic [2*CFG_W:0]   addr_full;
	logic               valid_q;

	assign ready_s2 = !valid_q || rsp.ready;
	assign row_base = (2*CFG_W)'(stage_s2.y) * (2*CFG_W)'(win.dest_width);
	assign addr_full = (2*CFG_W+1)'(row_base) + (2*CFG_W+1)'(stage_s2.x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_s2) begin
			valid_q <= stage_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && stage_s2.valid) begin
			rsp.write_enable <= stage_s2.write_enable;
			rsp.rejected     <= stage_s2.rejected;
			rsp.last         <= stage_s2.last;
			if (stage_s2.write_enable) begin
				rsp.dest_addr   <= addr_full[ADDR_W-1:0];
				rsp.write_pixel <= stage_s2.pixel;
			end else begin
				rsp.dest_addr   <= '0;
				rsp.write_pixel <= '0;
			end
		end
	end

	assign rsp.valid = valid_q;

	`CCKB_ASSERT_SAME(a_no_write_zero, clk, arst_n, rsp.valid && !rsp.write_enable,
		rsp.dest_addr == '0 && rsp.write_pixel == '0)
	`CCKB_ASSERT_SAME(a_write_not_rejected, clk, arst_n, rsp.valid && rsp.write_enable,
		!rsp.rejected)
endmodule

// ===== hdl/clipped_color_key_sprite_blit_core.sv =====
// Top level of the clipped color-key sprite blitter address engine.
// Pipeline: a request passes the input register, stage_s2 and the result register.
// Throughput: one request per cycle unless rsp.ready stalls the pipe; the raster
// counters and the address multiply each sit in their own stage.
// Reset: arst_n clears all valid flags and the sprite state, and loads the
// register defaults (640 by 480 destination, clip to destination extent).
module clipped_color_key_sprite_blit_core #(
	parameter int MAX_DIM = cckb_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = cckb_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cckb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cckb_pkg::CFG_W-1:0]     cfg_wdata,
	cckb_req_if.sink                       req,
	cckb_rsp_if.source                     rsp
);
	import cckb_pkg::*;

	win_t   win;
	stage_t stage_s2;
	logic   ready_s2;

	cckb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.win       (win)
	);

	cckb_geom #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.win      (win),
		.ready_s2 (ready_s2),
		.stage_s2 (stage_s2)
	);

	cckb_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s2 (stage_s2),
		.win      (win),
		.ready_s2 (ready_s2),
		.rsp      (rsp)
	);
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the clipped color-key sprite blitter address engine.
`timescale 1ns / 100ps

module tb_top;
	import cckb_pkg::*;

	localparam logic [PIX_FIELD_W-1:0] PIX_MASK =
		PIX_FIELD_W'((64'd1 << PIXEL_BITS_DEF) - 1);

	typedef struct {
		cmd_t                      cmd;
		logic [DIM_FIELD_W-1:0]    sprite_width;
		logic [DIM_FIELD_W-1:0]    sprite_height;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [PIX_FIELD_W-1:0]    pixel;
	} sprite_req_t;

	typedef struct {
		logic                   write_enable;
		logic [ADDR_W-1:0]      dest_addr;
		logic [PIX_FIELD_W-1:0] write_pixel;
		logic                   rejected;
		logic                   last;
	} blit_write_t;

	typedef struct {
		int l;
		int t;
		int r;
		int b;
	} rect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	cckb_req_if req();
	cckb_rsp_if rsp();

	clipped_color_key_sprite_blit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// Register mirror.
	int reg_dest_w = 640;
	int reg_dest_h = 480;
	int reg_mode = 0;
	int reg_clip_l = 0;
	int reg_clip_t = 0;
	int reg_clip_r = 640;
	int reg_clip_b = 480;

	// Sprite state mirror.
	int spr_corner_x = 0;
	int spr_corner_y = 0;
	int spr_w = 0;
	int spr_h = 0;
	int spr_col = 0;
	int spr_row = 0;
	bit spr_rejected = 1'b0;

	sprite_req_t pending_reqs[$];
	blit_write_t expected_writes[$];
	sprite_req_t cur_req;

	bit no_idle = 1'b0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_writes = 0;
	int n_sprites = 0;
	int n_rejects = 0;
	int n_settings = 1;

	function automatic rect_t clip_window();
		rect_t w;
		if (reg_mode == 1) begin
			w = '{reg_clip_l, reg_clip_t, reg_clip_r, reg_clip_b};
		end else begin
			w = '{0, 0, reg_dest_w, reg_dest_h};
		end
		return w;
	endfunction

	function automatic int clamp_dim(logic [DIM_FIELD_W-1:0] d);
		return (int'(d) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
	endfunction

	function automatic blit_write_t predict_write(sprite_req_t r);
		blit_write_t w;
		rect_t win;
		int x;
		int y;
		logic [PIX_FIELD_W-1:0] pv;
		w = '{default: '0};
		win = clip_window();
		if (r.cmd == CMD_BEGIN) begin
			spr_w = clamp_dim(r.sprite_width);
			spr_h = clamp_dim(r.sprite_height);
			spr_corner_x = int'(r.pos_x) - int'(r.origin_x);
			spr_corner_y = int'(r.pos_y) - int'(r.origin_y);
			spr_col = 0;
			spr_row = 0;
			spr_rejected = spr_corner_x >= win.r || spr_corner_x + spr_w <= win.l ||
				spr_corner_y >= win.b || spr_corner_y + spr_h <= win.t;
			n_sprites++;
			if (spr_rejected)
				n_rejects++;
		end else if (spr_w != 0 && spr_row < spr_h) begin
			x = spr_corner_x + spr_col;
			y = spr_corner_y + spr_row;
			pv = r.pixel & PIX_MASK;
			if (!spr_rejected && x >= win.l && x < win.r && y >= win.t && y < win.b &&
					pv != '0) begin
				w.write_enable = 1'b1;
				w.dest_addr = ADDR_W'(y * reg_dest_w + x);
				w.write_pixel = pv;
				n_writes++;
			end
			w.last = (spr_col + 1 == spr_w) && (spr_row + 1 == spr_h);
			spr_col++;
			if (spr_col >= spr_w) begin
				spr_col = 0;
				spr_row++;
			end
		end
		w.rejected = spr_rejected;
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				expected_writes.push_back(predict_write(cur_req));
				n_accepted++;
			end
			if (!req.valid || req.ready) begin
				if (pending_reqs.size() != 0 &&
						(no_idle || $urandom_range(0, 99) >= 27)) begin
					cur_req = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.cmd <= cur_req.cmd;
					req.sprite_width <= cur_req.sprite_width;
					req.sprite_height <= cur_req.sprite_height;
					req.origin_x <= cur_req.origin_x;
					req.origin_y <= cur_req.origin_y;
					req.pos_x <= cur_req.pos_x;
					req.pos_y <= cur_req.pos_y;
					req.pixel <= cur_req.pixel;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker.
	always @(posedge clk) begin
		blit_write_t exp_w;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf(
						"result with nothing expected: we=%0b addr=%0h pix=%0h rej=%0b last=%0b",
						rsp.write_enable, rsp.dest_addr, rsp.write_pixel, rsp.rejected,
						rsp.last));
				end else begin
					exp_w = expected_writes.pop_front();
					n_checked++;
					if (rsp.write_enable !== exp_w.write_enable ||
							rsp.dest_addr !== exp_w.dest_addr ||
							rsp.write_pixel !== exp_w.write_pixel ||
							rsp.rejected !== exp_w.rejected ||
							rsp.last !== exp_w.last)
						report_mismatch($sformatf({
							"result %0d expected we=%0b addr=%0h pix=%0h rej=%0b last=%0b, ",
							"got we=%0b addr=%0h pix=%0h rej=%0b last=%0b"},
							n_checked, exp_w.write_enable, exp_w.dest_addr, exp_w.write_pixel,
							exp_w.rejected, exp_w.last, rsp.write_enable, rsp.dest_addr,
							rsp.write_pixel, rsp.rejected, rsp.last));
				end
			end
			rsp.ready <= no_idle || $urandom_range(0, 99) >= 27;
		end
	end

	task automatic push_begin(int w, int h, int ox, int oy, int px, int py);
		sprite_req_t r;
		r = '{CMD_BEGIN, DIM_FIELD_W'(w), DIM_FIELD_W'(h), COORD_W'(ox), COORD_W'(oy),
			COORD_W'(px), COORD_W'(py), '0};
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic push_pixel(int p);
		sprite_req_t r;
		r = '{CMD_PIXEL, '0, '0, '0, '0, '0, '0, PIX_FIELD_W'(p)};
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	function automatic int random_pixel();
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 65535));
	endfunction

	function automatic int random_dim();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1)) :
			int'($urandom_range(1, 8));
	endfunction

	function automatic int random_corner(int lo, int hi);
		int span;
		span = hi - lo + 12;
		if ($urandom_range(0, 1) == 0)
			return (($urandom_range(0, 1) == 0) ? lo : hi) + int'($urandom_range(0, 12)) - 8;
		if (span < 1)
			return lo + int'($urandom_range(0, 60)) - 30;
		return lo - 10 + int'($urandom_range(0, span));
	endfunction

	task automatic queue_random_sprite();
		sprite_req_t r;
		rect_t win;
		int w;
		int h;
		int cx;
		int cy;
		int ox;
		int oy;
		int px;
		int py;
		int n;
		if ($urandom_range(0, 99) < 8) begin
			r.cmd = cmd_t'($urandom_range(0, 1));
			r.sprite_width = DIM_FIELD_W'($urandom);
			r.sprite_height = DIM_FIELD_W'($urandom);
			r.origin_x = COORD_W'($urandom);
			r.origin_y = COORD_W'($urandom);
			r.pos_x = COORD_W'($urandom);
			r.pos_y = COORD_W'($urandom);
			r.pixel = PIX_FIELD_W'($urandom);
			pending_reqs.push_back(r);
			n_queued++;
			return;
		end
		win = clip_window();
		w = random_dim();
		h = random_dim();
		cx = random_corner(win.l, win.r);
		cy = random_corner(win.t, win.b);
		ox = ($urandom_range(0, 3) == 0) ? int'(shortint'($urandom)) :
			int'($urandom_range(0, 40)) - 20;
		oy = ($urandom_range(0, 3) == 0) ? int'(shortint'($urandom)) :
			int'($urandom_range(0, 40)) - 20;
		px = cx + ox;
		py = cy + oy;
		if (px < -32768 || px > 32767) begin
			ox = 0;
			px = cx;
		end
		if (py < -32768 || py > 32767) begin
			oy = 0;
			py = cy;
		end
		push_begin(w, h, ox, oy, px, py);
		n = w * h;
		case ($urandom_range(0, 9))
			0: n = $urandom_range(0, n);
			1: n = n + $urandom_range(1, 3);
			default: ;
		endcase
		repeat (n) push_pixel(random_pixel());
	endtask

	task automatic write_reg(cfg_reg_t idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(value);
		case (idx)
			REG_DEST_WIDTH: reg_dest_w = value & 'h7FF;
			REG_DEST_HEIGHT: reg_dest_h = value & 'h7FF;
			REG_CLIP_MODE: reg_mode = value & 1;
			REG_CLIP_LEFT: reg_clip_l = value & 'h7FF;
			REG_CLIP_TOP: reg_clip_t = value & 'h7FF;
			REG_CLIP_RIGHT: reg_clip_r = value & 'h7FF;
			REG_CLIP_BOTTOM: reg_clip_b = value & 'h7FF;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || expected_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(int dw, int dh, int mode, int l, int t, int r, int b);
		wait_idle();
		write_reg(REG_DEST_WIDTH, dw);
		write_reg(REG_DEST_HEIGHT, dh);
		write_reg(REG_CLIP_MODE, mode);
		write_reg(REG_CLIP_LEFT, l);
		write_reg(REG_CLIP_TOP, t);
		write_reg(REG_CLIP_RIGHT, r);
		write_reg(REG_CLIP_BOTTOM, b);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_random(int count);
		int target;
		target = n_queued + count;
		while (n_queued < target)
			queue_random_sprite();
	endtask

	initial begin : stimulus
		int spin;
		req.valid = 1'b0;
		req.cmd = CMD_BEGIN;
		req.sprite_width = '0;
		req.sprite_height = '0;
		req.origin_x = '0;
		req.origin_y = '0;
		req.pos_x = '0;
		req.pos_y = '0;
		req.pixel = '0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEST_WIDTH;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: a pixel before any sprite, then edge and corner cases.
		push_pixel('hFFFF);
		push_begin(3, 2, 1, 1, 0, 0);
		push_pixel('hFFFF);
		push_pixel('h8000);
		push_pixel('h0001);
		push_pixel('h5555);
		push_pixel('h0000);
		push_pixel('hAAAA);
		push_pixel('h1234);
		push_begin(0, 5, 0, 0, 10, 10);
		push_pixel('h7777);
		push_begin(2047, 2047, 32767, 32767, -32768, -32768);
		push_pixel('h4321);
		push_begin(2047, 2047, -32768, -32768, 32767, 32767);
		push_begin(1, 1500, 0, 1024, 0, 0);
		push_begin(2047, 1, 1024, 0, 0, 0);
		push_begin(2, 1, 0, 0, 638, 479);
		push_pixel('h00FF);
		push_pixel('hFF00);
		push_begin(1, 1, 0, 0, 639, 479);
		push_pixel('h0F0F);
		run_random(40);

		program_regs(1, 1, 0, 5, 7, 3, 2);
		run_random(40);

		// A 1024 by 1024 destination and one full oversized sprite row.
		program_regs(1024, 1024, 0, 1024, 1024, 0, 0);
		push_begin(2047, 1, 0, 0, 5, 3);
		repeat (1024) push_pixel(random_pixel());
		run_random(20);

		// Long stretch without idling on either side.
		program_regs(40, 30, 1, 4, 3, 20, 12);
		no_idle = 1'b1;
		run_random(80);
		wait_idle();
		no_idle = 1'b0;

		program_regs(100, 100, 1, 10, 5, 10, 9);
		run_random(30);

		// Clip rectangle at the far corner of a 2047 by 2047 destination, addresses wrap.
		program_regs(2047, 2047, 1, 1000, 1000, 2047, 2047);
		run_random(40);

		program_regs(17, 5, 1, 0, 0, 1024, 1024);
		run_random(40);

		program_regs(0, 0, 0, 0, 0, 0, 0);
		run_random(20);

		program_regs($urandom_range(1, 64), $urandom_range(1, 64), 1, $urandom_range(0, 20),
			$urandom_range(0, 20), $urandom_range(10, 60), $urandom_range(10, 60));
		run_random(40);

		spin = 0;
		while ((n_accepted != n_queued || expected_writes.size() != 0) && spin < 100000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		if (expected_writes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_writes.size()));
		$display("Ran %0d requests under %0d register settings: %0d sprites (%0d rejected).",
			n_accepted, n_settings, n_sprites, n_rejects);
		$display("Checked %0d results with %0d pixel writes, %0d mismatches.",
			n_checked, n_writes, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Run timed out.");
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cckb_pkg.sv
hdl/cckb_req_if.sv
hdl/cckb_rsp_if.sv
hdl/cckb_cfg_regs.sv
hdl/cckb_geom.sv
hdl/cckb_addr.sv
hdl/clipped_color_key_sprite_blit_core.sv
tb/sv/tb_top.sv
